// File: rtl/core/pmei_pkg.sv
// Shared types, codes and saturating Q16.16 helpers for the point mass integrator.
`timescale 1ns / 1ps

package pmei_pkg;

    localparam int NUM_AXES = 3;

    typedef logic signed [31:0] q_t;
    typedef q_t [NUM_AXES-1:0]  vec3_t;

    typedef enum logic [2:0] {
        REQ_TICK        = 3'd0,
        REQ_ADD_FORCE   = 3'd1,
        REQ_CONST_FORCE = 3'd2,
        REQ_ABS_ACCEL   = 3'd3,
        REQ_IMPULSE     = 3'd4,
        REQ_VEL_CHANGE  = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        CFG_STEP_TIME      = 2'd0,
        CFG_INVERSE_MASS   = 2'd1,
        CFG_DAMPING_FACTOR = 2'd2
    } cfg_idx_t;

    localparam logic [16:0] STEP_TIME_RST      = 17'd1092;
    localparam logic [30:0] INVERSE_MASS_RST   = 31'd65536;
    localparam logic [16:0] DAMPING_FACTOR_RST = 17'd65536;

    typedef struct packed {
        logic [16:0] step_time;
        logic [30:0] inverse_mass;
        logic [16:0] damping_factor;
    } cfg_t;

    typedef struct packed {
        logic start;
        req_t req;
        logic ack;
    } lane_ctrl_t;

    // round half up, drop 16 fraction bits, clamp to 32 bits
    function automatic q_t rnd_sat(input logic signed [63:0] p);
        logic signed [64:0] s;
        logic signed [48:0] q;
        s = 65'(p) + 65'sd32768;
        q = 49'(s >>> 16);
        if (q[48:31] == '0 || q[48:31] == '1) begin
            return q[31:0];
        end else if (q[48]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

    function automatic q_t sat_add(input q_t a, input q_t b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] == s[31]) begin
            return s[31:0];
        end else if (s[32]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

endpackage

// File: rtl/core/pmei_lane.sv
// One axis of the integrator: axis state plus a sequencer around one shared multiplier.
`timescale 1ns / 1ps

module pmei_lane
    import pmei_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  lane_ctrl_t ctrl,
    input  cfg_t       cfg,
    input  q_t         vec_i,
    output logic       done,
    output q_t         pos_o,
    output q_t         vel_o,
    output q_t         acc_o
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_VDT,
        ST_T_POS,
        ST_T_TMP,
        ST_T_TIM,
        ST_T_V1,
        ST_T_V2,
        ST_T_VD,
        ST_T_V3,
        ST_SCALE,
        ST_CA_ADD,
        ST_VEL_ADD,
        ST_ACC_MUL,
        ST_ACC_ADD,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    req_t   req_reg;
    q_t     pos_reg, vel_reg, ca_reg, force_reg, tmp_reg, vec_reg, acc_reg;
    logic signed [63:0] prod_reg;

    q_t                 mul_a;
    logic [30:0]        mul_b;
    logic signed [32:0] mul_b_s;
    logic signed [63:0] prod_next;
    q_t                 prod_q;

    assign prod_q = rnd_sat(prod_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_T_VDT: begin
                mul_a = vel_reg;
                mul_b = 31'(cfg.step_time);
            end
            ST_T_POS: begin
                mul_a = force_reg;
                mul_b = 31'(cfg.step_time);
            end
            ST_T_TIM: begin
                mul_a = tmp_reg;
                mul_b = cfg.inverse_mass;
            end
            ST_T_V1: begin
                mul_a = ca_reg;
                mul_b = 31'(cfg.step_time);
            end
            ST_T_VD: begin
                mul_a = vel_reg;
                mul_b = 31'(cfg.damping_factor);
            end
            ST_SCALE: begin
                mul_a = vec_reg;
                mul_b = cfg.inverse_mass;
            end
            ST_ACC_MUL: begin
                mul_a = force_reg;
                mul_b = cfg.inverse_mass;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_b_s   = $signed({2'b00, mul_b});
    assign prod_next = 64'(mul_a) * 64'(mul_b_s);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (ctrl.start) begin
                    unique case (ctrl.req) inside
                        REQ_TICK:                    state_next = ST_T_VDT;
                        REQ_CONST_FORCE, REQ_IMPULSE: state_next = ST_SCALE;
                        default:                     state_next = ST_ACC_MUL;
                    endcase
                end
            end
            ST_T_VDT:   state_next = ST_T_POS;
            ST_T_POS:   state_next = ST_T_TMP;
            ST_T_TMP:   state_next = ST_T_TIM;
            ST_T_TIM:   state_next = ST_T_V1;
            ST_T_V1:    state_next = ST_T_V2;
            ST_T_V2:    state_next = ST_T_VD;
            ST_T_VD:    state_next = ST_T_V3;
            ST_T_V3:    state_next = ST_ACC_MUL;
            ST_SCALE:   state_next = (req_reg == REQ_CONST_FORCE) ? ST_CA_ADD : ST_VEL_ADD;
            ST_CA_ADD:  state_next = ST_ACC_MUL;
            ST_VEL_ADD: state_next = ST_ACC_MUL;
            ST_ACC_MUL: state_next = ST_ACC_ADD;
            ST_ACC_ADD: state_next = ST_DONE;
            ST_DONE:    state_next = ctrl.ack ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            vel_reg   <= '0;
            ca_reg    <= '0;
            force_reg <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (ctrl.start) begin
                        vec_reg <= vec_i;
                        req_reg <= ctrl.req;
                        case (ctrl.req)
                            REQ_ADD_FORCE:  force_reg <= sat_add(force_reg, vec_i);
                            REQ_ABS_ACCEL:  ca_reg    <= sat_add(ca_reg, vec_i);
                            REQ_VEL_CHANGE: vel_reg   <= sat_add(vel_reg, vec_i);
                            default: ;
                        endcase
                    end
                end
                ST_T_POS:   pos_reg   <= sat_add(pos_reg, prod_q);
                ST_T_TMP:   tmp_reg   <= prod_q;
                ST_T_V1:    vel_reg   <= sat_add(vel_reg, prod_q);
                ST_T_V2:    vel_reg   <= sat_add(vel_reg, prod_q);
                ST_T_V3: begin
                    vel_reg   <= prod_q;
                    force_reg <= '0;
                end
                ST_CA_ADD:  ca_reg    <= sat_add(ca_reg, prod_q);
                ST_VEL_ADD: vel_reg   <= sat_add(vel_reg, prod_q);
                ST_ACC_ADD: acc_reg   <= sat_add(ca_reg, prod_q);
                default: ;
            endcase
        end
    end

    assign done  = (state_reg == ST_DONE);
    assign pos_o = pos_reg;
    assign vel_o = vel_reg;
    assign acc_o = acc_reg;

endmodule

// File: rtl/core/pmei_merge.sv
// Merge stage: joins the three lanes into one result and holds it in the output register.
`timescale 1ns / 1ps

module pmei_merge
    import pmei_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [NUM_AXES-1:0] lane_done,
    input  vec3_t               pos_i,
    input  vec3_t               vel_i,
    input  vec3_t               acc_i,
    output logic                ack,
    output logic                m_valid,
    input  logic                m_ready,
    output vec3_t               pos_o,
    output vec3_t               vel_o,
    output vec3_t               acc_o
);

    logic  m_valid_reg;
    vec3_t pos_reg, vel_reg, acc_reg;

    // load when every lane is finished and the output slot is free or draining
    assign ack = (&lane_done) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ack) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (ack) begin
            pos_reg <= pos_i;
            vel_reg <= vel_i;
            acc_reg <= acc_i;
        end
    end

    assign m_valid = m_valid_reg;
    assign pos_o   = pos_reg;
    assign vel_o   = vel_reg;
    assign acc_o   = acc_reg;

endmodule

// File: rtl/core/point_mass_euler_integrator_3d.sv
// Top level of the 3D point mass Euler integrator: config registers, three lanes, merge.
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      s_req_type, s_vec_x/y/z
//  m_        out        m_valid / m_ready      m_pos_*, m_vel_*, m_acc_*
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request at a time; the x, y and z lanes run in lockstep, each with one multiplier.
// Add force, absolute accel and velocity change update lane state at accept; these and
// unused codes then recompute acceleration. Constant force and impulse first scale the
// vector by inverse mass. Tick runs five multiplies per lane, then the acceleration one.
// A result waiting on m_ready does not block the next request; cfg_ready is always high.
// Reset is synchronous: pos, vel, const accel, force clear to zero; cfg takes defaults.
`timescale 1ns / 1ps

module point_mass_euler_integrator_3d
    import pmei_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  q_t          s_vec_x,
    input  q_t          s_vec_y,
    input  q_t          s_vec_z,

    output logic        m_valid,
    input  logic        m_ready,
    output q_t          m_pos_x,
    output q_t          m_pos_y,
    output q_t          m_pos_z,
    output q_t          m_vel_x,
    output q_t          m_vel_y,
    output q_t          m_vel_z,
    output q_t          m_acc_x,
    output q_t          m_acc_y,
    output q_t          m_acc_z,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t                cfg_reg;
    logic                busy_reg;
    logic                s_fire;
    logic                ack;
    lane_ctrl_t          ctrl;
    logic [NUM_AXES-1:0] lane_done;
    vec3_t               vec_in, lane_pos, lane_vel, lane_acc;
    vec3_t               out_pos, out_vel, out_acc;

    assign cfg_ready = 1'b1;
    assign s_ready   = !busy_reg;
    assign s_fire    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_time      <= STEP_TIME_RST;
            cfg_reg.inverse_mass   <= INVERSE_MASS_RST;
            cfg_reg.damping_factor <= DAMPING_FACTOR_RST;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_STEP_TIME:      cfg_reg.step_time      <= cfg_data[16:0];
                CFG_INVERSE_MASS:   cfg_reg.inverse_mass   <= cfg_data[30:0];
                CFG_DAMPING_FACTOR: cfg_reg.damping_factor <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // one request in flight from accept until the merge stage takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (s_fire) begin
            busy_reg <= 1'b1;
        end else if (ack) begin
            busy_reg <= 1'b0;
        end
    end

    assign ctrl.start = s_fire;
    assign ctrl.req   = req_t'(s_req_type);
    assign ctrl.ack   = ack;

    assign vec_in[0] = s_vec_x;
    assign vec_in[1] = s_vec_y;
    assign vec_in[2] = s_vec_z;

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
        pmei_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .cfg     (cfg_reg),
            .vec_i   (vec_in[i]),
            .done    (lane_done[i]),
            .pos_o   (lane_pos[i]),
            .vel_o   (lane_vel[i]),
            .acc_o   (lane_acc[i])
        );
    end

    pmei_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .lane_done (lane_done),
        .pos_i     (lane_pos),
        .vel_i     (lane_vel),
        .acc_i     (lane_acc),
        .ack       (ack),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .pos_o     (out_pos),
        .vel_o     (out_vel),
        .acc_o     (out_acc)
    );

    assign m_pos_x = out_pos[0];
    assign m_pos_y = out_pos[1];
    assign m_pos_z = out_pos[2];
    assign m_vel_x = out_vel[0];
    assign m_vel_y = out_vel[1];
    assign m_vel_z = out_vel[2];
    assign m_acc_x = out_acc[0];
    assign m_acc_y = out_acc[1];
    assign m_acc_z = out_acc[2];

    // lanes share one sequence, so they finish together
    a_lanes_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (lane_done == '0) || (lane_done == '1))
        else $error("lanes out of step");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("second request taken while busy");

    a_ack_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ack |-> busy_reg)
        else $error("result merged with no request in flight");

    a_no_idle_done: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (lane_done == '0))
        else $error("lane finished while block idle");

endmodule
